### design/assert_macros.svh
// Assertion macros shared by the shaper curve RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define MSC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define MSC_ASSERT(label, clk, rst, prop)
`define MSC_ASSERT_NORST(label, clk, prop)
`endif
`endif

### design/msc_pkg.sv
// Shared types, register codes and clamp helpers for the shaper curve.
`timescale 1ns / 1ps
package msc_pkg;

  localparam int GAIN_CNT = 5;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_ORDER,
    REG_OFFSET,
    REG_SCALE,
    REG_GAIN_1,
    REG_GAIN_2,
    REG_GAIN_3,
    REG_GAIN_4,
    REG_GAIN_5
  } msc_reg_t;

  typedef enum logic {
    KIND_FWD,
    KIND_INV
  } msc_kind_t;

  typedef struct packed {
    msc_kind_t kind;
    logic      sat;
    logic      skip;
  } msc_ctl_t;

  typedef logic [GAIN_CNT-1:0][31:0] msc_gains_t;

  function automatic logic ovf64(input logic signed [63:0] x);
    return (x > 64'(VAL_MAX)) || (x < 64'(VAL_MIN));
  endfunction

  function automatic logic signed [31:0] clip64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (x < 64'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### design/msc_shaper.sv
// One pipelined rational bias/gain shaper slot.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msc_shaper #(
  parameter int SLOT      = 0,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [2:0]               n,
  input  msc_pkg::msc_gains_t      gains,
  input  logic                     in_valid,
  input  msc_pkg::msc_ctl_t        in_ctl,
  input  logic signed [31:0]       in_v,
  output logic                     out_valid,
  output msc_pkg::msc_ctl_t        out_ctl,
  output logic signed [31:0]       out_v
);

  localparam int ONE_W    = FRAC_BITS + 1;
  localparam int SEC_W    = 36 - FRAC_BITS;
  localparam int NUMW     = FRAC_BITS + 32;
  localparam int KD_STEPS = 8;
  localparam int KD_STG   = 5;
  localparam int KDW      = KD_STEPS * KD_STG;
  localparam logic [KDW-1:0] KOFF = KDW'(1) << 35;

  typedef struct packed {
    msc_pkg::msc_ctl_t   ctl;
    logic                act;
    logic [2:0]          k;
    logic signed [31:0]  v;
    logic signed [SEC_W-1:0] sec;
  } ctx_t;

  logic [ONE_W-1:0] one;
  assign one = ONE_W'(1) << FRAC_BITS;

  // stage A: section split
  logic                a_valid;
  ctx_t                a_ctx;
  logic signed [35:0]  a_vk;
  logic signed [32:0]  a_gs;

  logic                act;
  logic [2:0]          k;
  logic [2:0]          gi;
  logic signed [31:0]  gsel;
  logic signed [32:0]  gs;
  logic signed [35:0]  vk;

  always_comb begin
    act  = (3'(SLOT) < n) && !in_ctl.skip;
    k    = (in_ctl.kind == msc_pkg::KIND_FWD) ? 3'(SLOT + 1) : 3'(n - 3'(SLOT));
    gi   = k - 3'd1;
    gsel = act ? $signed(gains[gi]) : 32'sd0;
    gs   = (in_ctl.kind == msc_pkg::KIND_FWD) ? 33'(gsel) : -33'(gsel);
    vk   = in_v * $signed({1'b0, k});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx.ctl <= in_ctl;
      a_ctx.act <= act;
      a_ctx.k   <= k;
      a_ctx.v   <= in_v;
      a_ctx.sec <= '0;
      a_vk      <= vk;
      a_gs      <= gs;
    end
  end

  // stage B: curve denominator and numerator
  logic                   odd;
  logic signed [32:0]     g;
  logic                   gneg;
  logic [31:0]            mag;
  logic [FRAC_BITS-1:0]   f;
  logic [ONE_W-1:0]       w;
  logic [32+ONE_W-1:0]    m1;
  logic [32:0]            den;
  logic [NUMW-1:0]        num;

  always_comb begin
    odd  = a_vk[FRAC_BITS];
    g    = odd ? -a_gs : a_gs;
    gneg = g[32];
    mag  = gneg ? 32'(-g) : 32'(g);
    f    = a_vk[FRAC_BITS-1:0];
    w    = gneg ? {1'b0, f} : (one - {1'b0, f});
    m1   = mag * w;
    den  = 33'(one) + m1[32+ONE_W-1:FRAC_BITS];
    num  = gneg ? (f * (32'(one) + mag)) : NUMW'({f, {FRAC_BITS{1'b0}}});
  end

  // division of num by den, one quotient bit per stage
  logic                 d_valid [0:FRAC_BITS];
  ctx_t                 d_ctx   [0:FRAC_BITS];
  logic [32:0]          d_den   [0:FRAC_BITS];
  logic [32:0]          d_rem   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] d_low   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] d_q     [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctx[0].ctl <= a_ctx.ctl;
      d_ctx[0].act <= a_ctx.act;
      d_ctx[0].k   <= a_ctx.k;
      d_ctx[0].v   <= a_ctx.v;
      d_ctx[0].sec <= a_vk[35:FRAC_BITS];
      d_den[0]     <= den;
      d_rem[0]     <= 33'(num[NUMW-1:FRAC_BITS]);
      d_low[0]     <= num[FRAC_BITS-1:0];
      d_q[0]       <= '0;
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
    logic [33:0] t;
    logic        ge;
    always_comb begin
      t  = {d_rem[j], d_low[j][FRAC_BITS-1]};
      ge = t >= {1'b0, d_den[j]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[j+1] <= 1'b0;
      end else if (en) begin
        d_valid[j+1] <= d_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_ctx[j+1] <= d_ctx[j];
        d_den[j+1] <= d_den[j];
        d_rem[j+1] <= ge ? 33'(t - {1'b0, d_den[j]}) : t[32:0];
        d_low[j+1] <= d_low[j] << 1;
        d_q[j+1]   <= {d_q[j][FRAC_BITS-2:0], ge};
      end
    end
  end

  // stage C: rebuild the section, offset for floor division by k
  logic signed [35:0] x;
  assign x = $signed({d_ctx[FRAC_BITS].sec, d_q[FRAC_BITS]});

  logic           kd_valid [0:KD_STG];
  ctx_t           kd_ctx   [0:KD_STG];
  logic [2:0]     kd_rem   [0:KD_STG];
  logic [KDW-1:0] kd_low   [0:KD_STG];
  logic [KDW-1:0] kd_q     [0:KD_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      kd_valid[0] <= 1'b0;
    end else if (en) begin
      kd_valid[0] <= d_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd_ctx[0] <= d_ctx[FRAC_BITS];
      kd_rem[0] <= '0;
      kd_low[0] <= KDW'(x) + (KDW'(d_ctx[FRAC_BITS].k) << 35);
      kd_q[0]   <= '0;
    end
  end

  for (genvar s = 0; s < KD_STG; s++) begin : g_kd
    logic [2:0]     rr;
    logic [KDW-1:0] ll;
    logic [KDW-1:0] qq;
    logic [3:0]     tt;
    always_comb begin
      rr = kd_rem[s];
      ll = kd_low[s];
      qq = kd_q[s];
      tt = '0;
      for (int i = 0; i < KD_STEPS; i++) begin
        tt = {rr, ll[KDW-1]};
        ll = {ll[KDW-2:0], 1'b0};
        if (tt >= {1'b0, kd_ctx[s].k}) begin
          tt = tt - {1'b0, kd_ctx[s].k};
          qq = {qq[KDW-2:0], 1'b1};
        end else begin
          qq = {qq[KDW-2:0], 1'b0};
        end
        rr = tt[2:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        kd_valid[s+1] <= 1'b0;
      end else if (en) begin
        kd_valid[s+1] <= kd_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kd_ctx[s+1] <= kd_ctx[s];
        kd_rem[s+1] <= rr;
        kd_low[s+1] <= ll;
        kd_q[s+1]   <= qq;
      end
    end
  end

  // stage E: clamp and select
  logic signed [KDW-1:0] res;
  ctx_t                  ec;
  assign res = $signed(kd_q[KD_STG] - KOFF);
  assign ec  = kd_ctx[KD_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= kd_valid[KD_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.kind <= ec.ctl.kind;
      out_ctl.skip <= ec.ctl.skip;
      out_ctl.sat  <= ec.ctl.sat | (ec.act & msc_pkg::ovf64(64'(res)));
      out_v        <= ec.act ? msc_pkg::clip64(64'(res)) : ec.v;
    end
  end

  `MSC_ASSERT(a_k_nonzero, clk, rst, (a_valid && a_ctx.act) |-> (a_ctx.k != 3'd0))
  `MSC_ASSERT(a_frac_lt_one, clk, rst, (d_valid[FRAC_BITS] && d_ctx[FRAC_BITS].act) |-> (d_rem[FRAC_BITS] < d_den[FRAC_BITS]))
  `MSC_ASSERT(a_kd_rem_lt_k, clk, rst, (kd_valid[KD_STG] && kd_ctx[KD_STG].act) |-> (kd_rem[KD_STG] < kd_ctx[KD_STG].k))

endmodule

### design/monotonic_shaper_curve.sv
// Top level: monotonic shaper curve, forward and inverse, fully pipelined.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------
//  input     | in_valid, in_stall | kind, value_in
//  output    | out_valid, out_stall | value_out, saturated
//  config    | cfg_write          | cfg_index, cfg_data
//
// One transaction enters per cycle unless in_stall is high; pipeline depth is set by
// the 33-step inverse scale divider and, per shaper slot, the FRAC_BITS-step
// curve divider and the 5-stage divide by the section count.
// rst is synchronous, clears valid bits and config registers, and sets scale to one.
// The pipeline holds while a skid entry waits; in_stall is that registered flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module monotonic_shaper_curve #(
  parameter int MAX_STAGES = 5,
  parameter int FRAC_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value_out,
  output logic               saturated
);

  localparam int NW = 32 + FRAC_BITS;

  typedef struct packed {
    msc_pkg::msc_kind_t kind;
    logic               zs;
    logic               neg;
    logic               ovf;
    logic signed [32:0] dv;
    logic [31:0]        d;
  } iv_ctx_t;

  // configuration
  logic [2:0]          order;
  logic signed [31:0]  offset;
  logic signed [31:0]  scale;
  msc_pkg::msc_gains_t gains;
  logic [2:0]          n;

  always_ff @(posedge clk) begin
    if (rst) begin
      order  <= '0;
      offset <= '0;
      scale  <= 32'd1 << FRAC_BITS;
      gains  <= '0;
    end else if (cfg_write) begin
      unique case (msc_pkg::msc_reg_t'(cfg_index))
        msc_pkg::REG_ORDER:  order    <= cfg_data[2:0];
        msc_pkg::REG_OFFSET: offset   <= cfg_data;
        msc_pkg::REG_SCALE:  scale    <= cfg_data;
        msc_pkg::REG_GAIN_1: gains[0] <= cfg_data;
        msc_pkg::REG_GAIN_2: gains[1] <= cfg_data;
        msc_pkg::REG_GAIN_3: gains[2] <= cfg_data;
        msc_pkg::REG_GAIN_4: gains[3] <= cfg_data;
        msc_pkg::REG_GAIN_5: gains[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n = (order > 3'(MAX_STAGES)) ? 3'(MAX_STAGES) : order;

  // flow control
  logic en;
  logic skid_full;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  // F1: input register
  logic                f1_valid;
  msc_pkg::msc_kind_t  f1_kind;
  logic signed [31:0]  f1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_kind <= msc_pkg::msc_kind_t'(kind);
      f1_v    <= value_in;
    end
  end

  // F2: remove offset on inverse
  logic                f2_valid;
  msc_pkg::msc_kind_t  f2_kind;
  logic signed [32:0]  f2_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_kind <= f1_kind;
      f2_dv   <= (f1_kind == msc_pkg::KIND_INV) ? (33'(f1_v) - 33'(offset)) : 33'(f1_v);
    end
  end

  // F3: magnitudes and overflow check for the scale divide
  logic [31:0]       f3_mag;
  logic [31:0]       f3_dmag;
  logic [NW-1:0]     f3_num;
  logic [NW-34:0]    f3_top;
  logic              f3_ovf;

  always_comb begin
    f3_mag  = f2_dv[32] ? 32'(-f2_dv) : f2_dv[31:0];
    f3_dmag = scale[31] ? (~scale + 32'd1) : scale;
    f3_num  = {f3_mag, {FRAC_BITS{1'b0}}};
    f3_top  = f3_num[NW-1:33];
    f3_ovf  = 32'(f3_top) >= f3_dmag;
  end

  logic        iv_valid [0:33];
  iv_ctx_t     iv_ctx   [0:33];
  logic [31:0] iv_rem   [0:33];
  logic [32:0] iv_low   [0:33];
  logic [32:0] iv_q     [0:33];

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_valid[0] <= 1'b0;
    end else if (en) begin
      iv_valid[0] <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iv_ctx[0].kind <= f2_kind;
      iv_ctx[0].zs   <= (scale == 32'sd0);
      iv_ctx[0].neg  <= f2_dv[32] ^ scale[31];
      iv_ctx[0].ovf  <= f3_ovf;
      iv_ctx[0].dv   <= f2_dv;
      iv_ctx[0].d    <= f3_dmag;
      iv_rem[0]      <= f3_ovf ? 32'd0 : 32'(f3_top);
      iv_low[0]      <= f3_num[32:0];
      iv_q[0]        <= '0;
    end
  end

  for (genvar j = 0; j < 33; j++) begin : g_iv
    logic [32:0] t;
    logic        ge;
    always_comb begin
      t  = {iv_rem[j], iv_low[j][32]};
      ge = t >= {1'b0, iv_ctx[j].d};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        iv_valid[j+1] <= 1'b0;
      end else if (en) begin
        iv_valid[j+1] <= iv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        iv_ctx[j+1] <= iv_ctx[j];
        iv_rem[j+1] <= ge ? 32'(t - {1'b0, iv_ctx[j].d}) : t[31:0];
        iv_low[j+1] <= iv_low[j] << 1;
        iv_q[j+1]   <= {iv_q[j][31:0], ge};
      end
    end
  end

  // F4: on inverse, sign, floor and clamp of the scale quotient; zero scale saturates
  iv_ctx_t             fc;
  logic [33:0]         qa;
  msc_pkg::msc_ctl_t   f4_ctl_next;
  logic signed [31:0]  f4_v_next;

  always_comb begin
    fc               = iv_ctx[33];
    qa               = {1'b0, iv_q[33]} + 34'(fc.neg && (iv_rem[33] != 32'd0));
    f4_ctl_next.kind = fc.kind;
    f4_ctl_next.sat  = 1'b0;
    f4_ctl_next.skip = 1'b0;
    f4_v_next        = fc.dv[31:0];
    if (fc.kind == msc_pkg::KIND_INV) begin
      if (fc.zs) begin
        f4_ctl_next.sat  = 1'b1;
        f4_ctl_next.skip = 1'b1;
        f4_v_next        = fc.dv[32] ? msc_pkg::VAL_MIN : msc_pkg::VAL_MAX;
      end else if (fc.ovf) begin
        f4_ctl_next.sat = 1'b1;
        f4_v_next       = fc.neg ? msc_pkg::VAL_MIN : msc_pkg::VAL_MAX;
      end else if (!fc.neg) begin
        if (qa > 34'h0_7fff_ffff) begin
          f4_ctl_next.sat = 1'b1;
          f4_v_next       = msc_pkg::VAL_MAX;
        end else begin
          f4_v_next = qa[31:0];
        end
      end else begin
        if (qa > 34'h0_8000_0000) begin
          f4_ctl_next.sat = 1'b1;
          f4_v_next       = msc_pkg::VAL_MIN;
        end else begin
          f4_v_next = 32'(34'd0 - qa);
        end
      end
    end
  end

  logic               sl_valid [0:MAX_STAGES];
  msc_pkg::msc_ctl_t  sl_ctl   [0:MAX_STAGES];
  logic signed [31:0] sl_v     [0:MAX_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      sl_valid[0] <= 1'b0;
    end else if (en) begin
      sl_valid[0] <= iv_valid[33];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl_ctl[0] <= f4_ctl_next;
      sl_v[0]   <= f4_v_next;
    end
  end

  // shaper slots
  for (genvar s = 0; s < MAX_STAGES; s++) begin : g_slot
    msc_shaper #(
      .SLOT      (s),
      .FRAC_BITS (FRAC_BITS)
    ) u_shaper (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .n         (n),
      .gains     (gains),
      .in_valid  (sl_valid[s]),
      .in_ctl    (sl_ctl[s]),
      .in_v      (sl_v[s]),
      .out_valid (sl_valid[s+1]),
      .out_ctl   (sl_ctl[s+1]),
      .out_v     (sl_v[s+1])
    );
  end

  // B1: scale product on forward; inverse values pass through unscaled
  logic               b1_valid;
  msc_pkg::msc_ctl_t  b1_ctl;
  logic signed [63:0] b1_prod;
  logic signed [63:0] prod_next;
  logic signed [31:0] last_v;

  assign last_v    = sl_v[MAX_STAGES];
  assign prod_next = (sl_ctl[MAX_STAGES].kind == msc_pkg::KIND_FWD) ?
                     (last_v * scale) : (64'(last_v) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= sl_valid[MAX_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_ctl  <= sl_ctl[MAX_STAGES];
      b1_prod <= prod_next;
    end
  end

  // B2: rescale and clamp
  logic               b2_valid;
  msc_pkg::msc_ctl_t  b2_ctl;
  logic signed [31:0] b2_v;
  logic signed [63:0] sh;

  assign sh = b1_prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (en) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_ctl.kind <= b1_ctl.kind;
      b2_ctl.skip <= b1_ctl.skip;
      b2_ctl.sat  <= b1_ctl.sat | msc_pkg::ovf64(sh);
      b2_v        <= msc_pkg::clip64(sh);
    end
  end

  // B3: add offset on forward and clamp
  logic               b3_valid;
  msc_pkg::msc_ctl_t  b3_ctl;
  logic signed [31:0] b3_v;
  logic signed [32:0] sum;

  assign sum = (b2_ctl.kind == msc_pkg::KIND_FWD) ? (33'(b2_v) + 33'(offset)) : 33'(b2_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else if (en) begin
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_ctl.kind <= b2_ctl.kind;
      b3_ctl.skip <= b2_ctl.skip;
      b3_ctl.sat  <= b2_ctl.sat | msc_pkg::ovf64(64'(sum));
      b3_v        <= msc_pkg::clip64(64'(sum));
    end
  end

  // output register with skid entry
  logic               push;
  logic               take;
  logic signed [31:0] skid_v;
  logic               skid_sat;

  assign push = b3_valid && en;
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        value_out <= skid_v;
        saturated <= skid_sat;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_v   <= b3_v;
        skid_sat <= b3_ctl.sat;
      end else begin
        value_out <= b3_v;
        saturated <= b3_ctl.sat;
      end
    end
  end

  `MSC_ASSERT(a_skid_needs_out, clk, rst, skid_full |-> out_valid)
  `MSC_ASSERT(a_skid_on_stall, clk, rst, $rose(skid_full) |-> $past(out_valid && out_stall))
  `MSC_ASSERT(a_zero_scale_sat, clk, rst, (sl_valid[0] && sl_ctl[0].skip) |-> sl_ctl[0].sat)
  `MSC_ASSERT(a_iv_rem_lt_d, clk, rst, (iv_valid[33] && !iv_ctx[33].zs && !iv_ctx[33].ovf) |-> (iv_rem[33] < iv_ctx[33].d))

endmodule

### sim/tb.sv
// Testbench for monotonic_shaper_curve: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb;

  localparam int        STAGES  = 5;
  localparam int        FRAC    = 24;
  localparam int        LATENCY = 41 + STAGES * (FRAC + 9);
  localparam int        LIMIT   = 20000;
  localparam longint    ONE     = 64'sd1 << FRAC;
  localparam longint    VMAX    = 64'sd2147483647;
  localparam longint    VMIN    = -64'sd2147483648;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic signed [31:0] value_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] value_out;
  logic               saturated;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } curve_result_t;

  curve_result_t pending_results[$];

  logic [2:0] order_reg;
  longint     offset_reg;
  longint     scale_reg;
  longint     gain_reg[STAGES];

  bit  quiet;
  int  hold_cycles;
  int  mismatches;
  int  idle_cycles;

  monotonic_shaper_curve #(.MAX_STAGES(STAGES), .FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .value_out(value_out), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_div(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clamp_word(longint v, inout bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint shape_section(longint v, longint gain, longint k, inout bit sat);
    longint vk, sec, f, g, den, r;
    vk  = v * k;
    sec = floor_div(vk, ONE);
    f   = vk - sec * ONE;
    g   = sec[0] ? -gain : gain;
    if (g >= 0) begin
      den = ONE + (g * (ONE - f)) / ONE;
      r   = (f * ONE) / den;
    end else begin
      den = ONE + (-g * f) / ONE;
      r   = (f * (ONE - g)) / den;
    end
    return clamp_word(floor_div(sec * ONE + r, k), sat);
  endfunction

  function automatic curve_result_t predict_curve(msc_pkg::msc_kind_t k,
                                                  logic signed [31:0] x);
    curve_result_t res;
    bit            sat;
    longint        v, n;
    sat = 1'b0;
    v   = x;
    n   = (order_reg > STAGES) ? STAGES : order_reg;
    if (k == msc_pkg::KIND_FWD) begin
      for (longint s = 1; s <= n; s++) v = shape_section(v, gain_reg[s-1], s, sat);
      v = clamp_word(floor_div(v * scale_reg, ONE), sat);
      v = clamp_word(v + offset_reg, sat);
    end else begin
      v = v - offset_reg;
      if (scale_reg == 0) begin
        sat = 1'b1;
        v   = (v >= 0) ? VMAX : VMIN;
      end else begin
        v = clamp_word(floor_div(v * ONE, scale_reg), sat);
        for (longint s = n; s >= 1; s--) v = shape_section(v, -gain_reg[s-1], s, sat);
      end
    end
    res.value = v[31:0];
    res.sat   = sat;
    return res;
  endfunction

  task automatic send_item(msc_pkg::msc_kind_t k, logic signed [31:0] x);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value_in <= x;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_curve(k, x));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(msc_pkg::msc_reg_t idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      msc_pkg::REG_ORDER:  order_reg  = data[2:0];
      msc_pkg::REG_OFFSET: offset_reg = longint'($signed(data));
      msc_pkg::REG_SCALE:  scale_reg  = longint'($signed(data));
      default: gain_reg[int'(idx) - int'(msc_pkg::REG_GAIN_1)] = longint'($signed(data));
    endcase
  endtask

  task automatic load_curve(logic [2:0] order, logic [31:0] offs, logic [31:0] scl,
                            logic [31:0] g1, logic [31:0] g2, logic [31:0] g3,
                            logic [31:0] g4, logic [31:0] g5);
    drain();
    write_reg(msc_pkg::REG_ORDER, {29'd0, order});
    write_reg(msc_pkg::REG_OFFSET, offs);
    write_reg(msc_pkg::REG_SCALE, scl);
    write_reg(msc_pkg::REG_GAIN_1, g1);
    write_reg(msc_pkg::REG_GAIN_2, g2);
    write_reg(msc_pkg::REG_GAIN_3, g3);
    write_reg(msc_pkg::REG_GAIN_4, g4);
    write_reg(msc_pkg::REG_GAIN_5, g5);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] rand_gain();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(32'h0800_0000) - 32'h0400_0000;
  endfunction

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(9) < 7) return $urandom_range(32'h0100_0000);
    return $urandom;
  endfunction

  task automatic send_extremes;
    logic signed [31:0] pts[8];
    pts = '{32'sh0, 32'sh0100_0000, 32'sh0080_0000, 32'sh7fff_ffff,
            32'sh8000_0000, -32'sh1, 32'sh1, 32'sh00ff_ffff};
    foreach (pts[i]) begin
      send_item(msc_pkg::KIND_FWD, pts[i]);
      send_item(msc_pkg::KIND_INV, pts[i]);
    end
  endtask

  task automatic test_reset_defaults;
    send_extremes();
  endtask

  task automatic test_directed_curves;
    load_curve(3'd5, 32'h0, 32'h0100_0000, 32'h0200_0000, 32'hfe00_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h0080_0000);
    send_extremes();
    load_curve(3'd7, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff,
               32'h0, 32'h0100_0000, 32'hff00_0000);
    send_extremes();
    load_curve(3'd1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
               32'h0, 32'h0, 32'h0);
    send_extremes();
  endtask

  task automatic test_random_items;
    for (int phase = 0; phase < 6; phase++) begin
      load_curve(3'($urandom_range(7)),
                 (phase == 3) ? 32'h0 : $urandom_range(32'h0200_0000) - 32'h0100_0000,
                 (phase == 4) ? 32'h0 : (phase == 5) ? $urandom
                                      : $urandom_range(32'h0400_0000) - 32'h0200_0000,
                 rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      quiet = (phase == 2);
      repeat (180) send_item(msc_pkg::msc_kind_t'($urandom_range(1)), rand_value());
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure;
    load_curve(3'd5, 32'h0010_0000, 32'h0180_0000, rand_gain(), rand_gain(),
               rand_gain(), rand_gain(), rand_gain());
    hold_cycles = 600;
    repeat (400) send_item(msc_pkg::msc_kind_t'($urandom_range(1)), rand_value());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    curve_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: value %h sat %b",
                                       value_out, saturated);
      end else begin
        want = pending_results.pop_front();
        if (want.value !== value_out || want.sat !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h sat %b, actual value %h sat %b",
                     want.value, want.sat, value_out, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = msc_pkg::REG_ORDER;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = msc_pkg::KIND_FWD;
    value_in   = '0;
    quiet      = 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    idle_cycles = 0;
    order_reg  = '0;
    offset_reg = 0;
    scale_reg  = ONE;
    foreach (gain_reg[i]) gain_reg[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_curves();
    test_random_items();
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### monotonic_shaper_curve.f
+incdir+design
design/msc_pkg.sv
design/msc_shaper.sv
design/monotonic_shaper_curve.sv
sim/tb.sv
